>>> rtl/rcc_pkg.sv
`timescale 1ns / 1ps
package rcc_pkg;

	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 16;
	localparam int PW         = 2 * WORD_BITS;
	localparam int DIST_BITS  = 31;
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;
	localparam int DIV_STEPS  = WORD_BITS - 1;
	localparam int DIV_LAT    = DIV_STEPS + 1;
	localparam int SQRT_STEPS = (WORD_BITS + FRAC_BITS) / 2;
	localparam int SQRT_LAT   = SQRT_STEPS + 1;
	localparam int PIPE_LAT   = 2 * DIV_LAT + SQRT_LAT + 12;

	localparam logic REG_MISS = 1'b0;
	localparam logic [DIST_BITS-1:0] MISS_RESET = '1;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [WORD_BITS-1:0] umag_t;

	localparam word_t WMAX     = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WMIN     = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam word_t HALF     = word_t'(64'(1) << (FRAC_BITS - 1));
	localparam word_t NEG_HALF = -HALF;
	localparam word_t QUARTER  = word_t'(64'(1) << (FRAC_BITS - 2));
	localparam word_t ONE_RAW  = word_t'(1);

	typedef struct packed {
		word_t origin_x;
		word_t origin_y;
		word_t origin_z;
		word_t origin_w;
		word_t dir_x;
		word_t dir_y;
		word_t dir_z;
	} ray_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] hit_distance;
		logic                 hit;
	} res_t;

	function automatic word_t sat_ext(input logic [WORD_BITS:0] v);
		word_t r;
		if (v[WORD_BITS] != v[WORD_BITS-1]) begin
			r = v[WORD_BITS] ? WMIN : WMAX;
		end else begin
			r = v[WORD_BITS-1:0];
		end
		return r;
	endfunction

	function automatic word_t qadd(input word_t a, input word_t b);
		return sat_ext({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
	endfunction

	function automatic word_t qsub(input word_t a, input word_t b);
		return sat_ext({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b});
	endfunction

	function automatic umag_t mag(input word_t a);
		logic [WORD_BITS:0] e;
		e = {a[WORD_BITS-1], a};
		if (a[WORD_BITS-1]) begin
			e = -e;
		end
		return e[WORD_BITS-1:0];
	endfunction

	function automatic word_t qmul(input word_t a, input word_t b);
		logic [PW-1:0] p;
		logic [PW-1:0] lim;
		logic [WORD_BITS:0] v;
		logic neg;
		neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
		p = PW'(mag(a)) * PW'(mag(b));
		p = p >> FRAC_BITS;
		lim = neg ? PW'(umag_t'(WMAX)) + PW'(1) : PW'(umag_t'(WMAX));
		if (p > lim) begin
			p = lim;
		end
		v = p[WORD_BITS:0];
		if (neg) begin
			v = -v;
		end
		return v[WORD_BITS-1:0];
	endfunction

endpackage

>>> rtl/rcc_div.sv
`timescale 1ns / 1ps
module rcc_div import rcc_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t num,
	input  word_t den,
	output word_t quo,
	output logic  ok
);

	localparam int NW = WORD_BITS + FRAC_BITS;
	localparam int CW = 2 * WORD_BITS - 1;

	logic [NW-1:0]        rem_q [0:DIV_STEPS];
	umag_t                dv_q  [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] qt_q  [0:DIV_STEPS];
	logic                 neg_q [0:DIV_STEPS];
	logic                 ovf_q [0:DIV_STEPS];
	logic [NW-1:0]        num_m;
	umag_t                den_m;
	logic [WORD_BITS:0]   qx;

	assign num_m = {mag(num), {FRAC_BITS{1'b0}}};
	assign den_m = mag(den);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= num_m;
			dv_q[0]  <= den_m;
			qt_q[0]  <= '0;
			neg_q[0] <= num[WORD_BITS-1] ^ den[WORD_BITS-1];
			ovf_q[0] <= {den_m, {(WORD_BITS-1){1'b0}}} <= CW'(num_m);
		end
	end

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
		logic [CW-1:0] trial;
		logic          fit;

		assign trial = CW'(dv_q[j-1]) << (DIV_STEPS - j);
		assign fit   = CW'(rem_q[j-1]) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= fit ? rem_q[j-1] - trial[NW-1:0] : rem_q[j-1];
				qt_q[j]  <= {qt_q[j-1][DIV_STEPS-2:0], fit};
				dv_q[j]  <= dv_q[j-1];
				neg_q[j] <= neg_q[j-1];
				ovf_q[j] <= ovf_q[j-1];
			end
		end
	end

	always_comb begin
		qx = (WORD_BITS+1)'(qt_q[DIV_STEPS]);
		if (neg_q[DIV_STEPS]) begin
			qx = -qx;
		end
	end

	assign quo = qx[WORD_BITS-1:0];
	assign ok  = !ovf_q[DIV_STEPS];

endmodule

>>> rtl/rcc_sqrt.sv
`timescale 1ns / 1ps
module rcc_sqrt import rcc_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t rad,
	output word_t root
);

	localparam int NW = WORD_BITS + FRAC_BITS;
	localparam int TW = 2 * SQRT_STEPS + 2;

	logic [NW-1:0]         rem_q [0:SQRT_STEPS];
	logic [SQRT_STEPS-1:0] rt_q  [0:SQRT_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= (rad > 0) ? {umag_t'(rad), {FRAC_BITS{1'b0}}} : '0;
			rt_q[0]  <= '0;
		end
	end

	for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_step
		logic [TW-1:0] trial;
		logic          fit;

		assign trial = TW'({rt_q[j-1], 2'b01}) << (2 * (SQRT_STEPS - j));
		assign fit   = TW'(rem_q[j-1]) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= fit ? rem_q[j-1] - trial[NW-1:0] : rem_q[j-1];
				rt_q[j]  <= {rt_q[j-1][SQRT_STEPS-2:0], fit};
			end
		end
	end

	assign root = (TW'(rt_q[SQRT_STEPS]) > TW'(umag_t'(WMAX))) ? WMAX
		: word_t'(rt_q[SQRT_STEPS]);

endmodule

>>> rtl/ray_capped_cylinder_intersect.sv
`timescale 1ns / 1ps
// Capped cylinder ray test (radius 0.5, height 1, centered, y axis), signed Q16.16.
// Ray channel: ray_valid / ray_stall / ray carries one ray word (homogeneous
//   origin x,y,z,w and direction x,y,z); taken at a clock edge with valid high
//   and stall low.
// Result channel: res_valid / res_stall / res carries hit_distance and hit,
//   one result word per ray, in ray order.
// APB port: register 0 at byte address 0 is miss_distance (31 bits, reset
//   0x7FFFFFFF); write it only while no ray is in flight.
// Throughput: one ray per cycle while the result is not stalled; the two
//   banks of pipelined dividers (32 stages each) and the pipelined square
//   root (25 stages) set the depth.
// Stall: a stalled result holds; the pipeline freezes as a whole and
//   ray_stall rises in the same cycle, so nothing is lost or repeated.
//   Bubbles in the pipeline advance whenever the result slot is empty.
// Reset: arst_n clears all valid bits and restores miss_distance; the block
//   takes rays in the first cycle after reset.
module ray_capped_cylinder_intersect import rcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 ray_valid,
	output logic                 ray_stall,
	input  ray_t                 ray,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	typedef struct packed {
		word_t px;
		word_t py;
		word_t pz;
		word_t vx;
		word_t vy;
		word_t vz;
		logic  live;
	} geo_t;

	typedef struct packed {
		word_t vx;
		word_t vy;
		word_t vz;
		logic  wzero;
	} side1_t;

	typedef struct packed {
		geo_t  geo;
		word_t b;
		word_t den;
		logic  wall;
	} side2_t;

	typedef struct packed {
		geo_t geo;
		logic wall;
		logic cap;
	} side3_t;

	logic                 en;
	logic [PIPE_LAT:1]    vld_q;
	logic [DIST_BITS-1:0] miss_q;

	ray_t   ray_s1;
	word_t  dw_s1;
	side1_t side1_q [1:DIV_LAT];
	side2_t side2_q [1:SQRT_LAT];
	side3_t side3_q [1:DIV_LAT];

	word_t px_d, py_d, pz_d;
	logic  okx_d, oky_d, okz_d;

	geo_t  geo_s2;
	word_t vxx_s2, vzz_s2, pxvx_s2, pzvz_s2, pxx_s2, pzz_s2;

	geo_t  geo_s3;
	word_t a_s3, h_s3, c_s3;

	geo_t  geo_s4;
	word_t b_s4, ac_s4, den_s4;

	geo_t  geo_s5;
	word_t b_s5, den_s5, bb_s5, ac4_s5;
	word_t ac2_c;

	geo_t  geo_s6;
	word_t b_s6, den_s6, delta_s6;

	word_t s_d;
	geo_t  geo_s7;
	word_t n1_s7, n2_s7, capn_s7, dw_s7, dc_s7;
	logic  wall_s7, cap_s7;

	word_t t1_d, t2_d, t3_d;
	logic  ok1_d, ok2_d, ok3_d;

	geo_t  geo_s8;
	word_t t1_s8, t2_s8, t3_s8, ty1_s8, ty2_s8, tx_s8, tz_s8;
	logic  v1_s8, v2_s8, v3_s8;

	word_t t1_s9, t2_s9, t3_s9, y1_s9, y2_s9, x_s9, z_s9;
	logic  v1_s9, v2_s9, v3_s9;

	word_t t1_s10, t2_s10, t3_s10, xx_s10, zz_s10;
	logic  v1_s10, v2_s10, v3_s10;

	word_t t1_s11, t2_s11, t3_s11;
	logic  acc1_s11, acc2_s11, acc3_s11;

	logic [DIST_BITS-1:0] best_c;
	res_t                 res_s12;

	assign en        = !res_valid || !res_stall;
	assign ray_stall = !en;
	assign res_valid = vld_q[PIPE_LAT];
	assign res       = res_s12;

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_BITS-1] == REG_MISS) ? DATA_BITS'(miss_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q <= MISS_RESET;
		end else if (psel && penable && pwrite && paddr[ADDR_BITS-1] == REG_MISS) begin
			miss_q <= pwdata[DIST_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-1:1], ray_valid};
		end
	end

	// origin divide by w
	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= ray;
		end
	end

	assign dw_s1 = (ray_s1.origin_w == '0) ? ONE_RAW : ray_s1.origin_w;

	rcc_div u_div_x (.clk, .en, .num(ray_s1.origin_x), .den(dw_s1), .quo(px_d), .ok(okx_d));
	rcc_div u_div_y (.clk, .en, .num(ray_s1.origin_y), .den(dw_s1), .quo(py_d), .ok(oky_d));
	rcc_div u_div_z (.clk, .en, .num(ray_s1.origin_z), .den(dw_s1), .quo(pz_d), .ok(okz_d));

	always_ff @(posedge clk) begin
		if (en) begin
			side1_q[1] <= '{vx: ray_s1.dir_x, vy: ray_s1.dir_y, vz: ray_s1.dir_z,
				wzero: ray_s1.origin_w == '0};
			for (int k = 2; k <= DIV_LAT; k++) begin
				side1_q[k] <= side1_q[k-1];
			end
		end
	end

	// quadratic coefficients
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2 <= '{px: px_d, py: py_d, pz: pz_d,
				vx: side1_q[DIV_LAT].vx, vy: side1_q[DIV_LAT].vy, vz: side1_q[DIV_LAT].vz,
				live: !side1_q[DIV_LAT].wzero && okx_d && oky_d && okz_d};
			vxx_s2  <= qmul(side1_q[DIV_LAT].vx, side1_q[DIV_LAT].vx);
			vzz_s2  <= qmul(side1_q[DIV_LAT].vz, side1_q[DIV_LAT].vz);
			pxvx_s2 <= qmul(px_d, side1_q[DIV_LAT].vx);
			pzvz_s2 <= qmul(pz_d, side1_q[DIV_LAT].vz);
			pxx_s2  <= qmul(px_d, px_d);
			pzz_s2  <= qmul(pz_d, pz_d);

			geo_s3 <= geo_s2;
			a_s3   <= qadd(vxx_s2, vzz_s2);
			h_s3   <= qadd(pxvx_s2, pzvz_s2);
			c_s3   <= qsub(qadd(pxx_s2, pzz_s2), QUARTER);

			geo_s4 <= geo_s3;
			b_s4   <= qadd(h_s3, h_s3);
			ac_s4  <= qmul(a_s3, c_s3);
			den_s4 <= qadd(a_s3, a_s3);

			geo_s5 <= geo_s4;
			b_s5   <= b_s4;
			den_s5 <= den_s4;
			bb_s5  <= qmul(b_s4, b_s4);
			ac4_s5 <= qadd(ac2_c, ac2_c);

			geo_s6   <= geo_s5;
			b_s6     <= b_s5;
			den_s6   <= den_s5;
			delta_s6 <= qsub(bb_s5, ac4_s5);
		end
	end

	assign ac2_c = qadd(ac_s4, ac_s4);

	// wall root
	rcc_sqrt u_sqrt (.clk, .en, .rad(delta_s6), .root(s_d));

	always_ff @(posedge clk) begin
		if (en) begin
			side2_q[1] <= '{geo: geo_s6, b: b_s6, den: den_s6,
				wall: (delta_s6 > 0) && (den_s6 != '0)};
			for (int k = 2; k <= SQRT_LAT; k++) begin
				side2_q[k] <= side2_q[k-1];
			end
		end
	end

	// candidate numerators and divisors
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s7  <= side2_q[SQRT_LAT].geo;
			n1_s7   <= qsub(s_d, side2_q[SQRT_LAT].b);
			n2_s7   <= qsub(qsub('0, side2_q[SQRT_LAT].b), s_d);
			capn_s7 <= side2_q[SQRT_LAT].geo.vy[WORD_BITS-1]
				? qsub(HALF, side2_q[SQRT_LAT].geo.py)
				: qsub(NEG_HALF, side2_q[SQRT_LAT].geo.py);
			dw_s7   <= side2_q[SQRT_LAT].wall ? side2_q[SQRT_LAT].den : ONE_RAW;
			dc_s7   <= (side2_q[SQRT_LAT].geo.vy != '0) ? side2_q[SQRT_LAT].geo.vy : ONE_RAW;
			wall_s7 <= side2_q[SQRT_LAT].wall;
			cap_s7  <= side2_q[SQRT_LAT].geo.vy != '0;
		end
	end

	rcc_div u_div_t1 (.clk, .en, .num(n1_s7), .den(dw_s7), .quo(t1_d), .ok(ok1_d));
	rcc_div u_div_t2 (.clk, .en, .num(n2_s7), .den(dw_s7), .quo(t2_d), .ok(ok2_d));
	rcc_div u_div_t3 (.clk, .en, .num(capn_s7), .den(dc_s7), .quo(t3_d), .ok(ok3_d));

	always_ff @(posedge clk) begin
		if (en) begin
			side3_q[1] <= '{geo: geo_s7, wall: wall_s7, cap: cap_s7};
			for (int k = 2; k <= DIV_LAT; k++) begin
				side3_q[k] <= side3_q[k-1];
			end
		end
	end

	// hit point checks and selection
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s8 <= side3_q[DIV_LAT].geo;
			t1_s8  <= t1_d;
			t2_s8  <= t2_d;
			t3_s8  <= t3_d;
			v1_s8  <= side3_q[DIV_LAT].geo.live && side3_q[DIV_LAT].wall && ok1_d;
			v2_s8  <= side3_q[DIV_LAT].geo.live && side3_q[DIV_LAT].wall && ok2_d;
			v3_s8  <= side3_q[DIV_LAT].geo.live && side3_q[DIV_LAT].cap && ok3_d;
			ty1_s8 <= qmul(t1_d, side3_q[DIV_LAT].geo.vy);
			ty2_s8 <= qmul(t2_d, side3_q[DIV_LAT].geo.vy);
			tx_s8  <= qmul(t3_d, side3_q[DIV_LAT].geo.vx);
			tz_s8  <= qmul(t3_d, side3_q[DIV_LAT].geo.vz);

			t1_s9 <= t1_s8;
			t2_s9 <= t2_s8;
			t3_s9 <= t3_s8;
			v1_s9 <= v1_s8;
			v2_s9 <= v2_s8;
			v3_s9 <= v3_s8;
			y1_s9 <= qadd(geo_s8.py, ty1_s8);
			y2_s9 <= qadd(geo_s8.py, ty2_s8);
			x_s9  <= qadd(geo_s8.px, tx_s8);
			z_s9  <= qadd(geo_s8.pz, tz_s8);

			t1_s10 <= t1_s9;
			t2_s10 <= t2_s9;
			t3_s10 <= t3_s9;
			v1_s10 <= v1_s9 && (y1_s9 >= NEG_HALF) && (y1_s9 <= HALF);
			v2_s10 <= v2_s9 && (y2_s9 >= NEG_HALF) && (y2_s9 <= HALF);
			v3_s10 <= v3_s9;
			xx_s10 <= qmul(x_s9, x_s9);
			zz_s10 <= qmul(z_s9, z_s9);

			t1_s11   <= t1_s10;
			t2_s11   <= t2_s10;
			t3_s11   <= t3_s10;
			acc1_s11 <= v1_s10 && !t1_s10[WORD_BITS-1] && (PW'(t1_s10) < PW'(miss_q));
			acc2_s11 <= v2_s10 && !t2_s10[WORD_BITS-1] && (PW'(t2_s10) < PW'(miss_q));
			acc3_s11 <= v3_s10 && (qadd(xx_s10, zz_s10) <= QUARTER)
				&& !t3_s10[WORD_BITS-1] && (PW'(t3_s10) < PW'(miss_q));

			res_s12.hit_distance <= best_c;
			res_s12.hit          <= acc1_s11 || acc2_s11 || acc3_s11;
		end
	end

	always_comb begin
		best_c = miss_q;
		if (acc1_s11) begin
			best_c = DIST_BITS'(t1_s11);
		end
		if (acc2_s11 && DIST_BITS'(t2_s11) < best_c) begin
			best_c = DIST_BITS'(t2_s11);
		end
		if (acc3_s11 && DIST_BITS'(t3_s11) < best_c) begin
			best_c = DIST_BITS'(t3_s11);
		end
	end

endmodule

>>> rtl/rcc_check.sv
`timescale 1ns / 1ps
module rcc_check import rcc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 ray_stall,
	input logic                 res_valid,
	input logic                 res_stall,
	input res_t                 res,
	input logic                 psel,
	input logic                 penable,
	input logic                 pwrite,
	input logic [ADDR_BITS-1:0] paddr,
	input logic [DATA_BITS-1:0] pwdata,
	input logic [DATA_BITS-1:0] prdata
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("result word changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		ray_stall == (res_valid && res_stall))
		else $error("ray stall does not follow result stall");

	a_hit_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.hit |-> res.hit_distance != MISS_RESET)
		else $error("hit reported at the largest distance");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[ADDR_BITS-1] == REG_MISS)
		|=> (paddr[ADDR_BITS-1] != REG_MISS)
			|| (prdata == DATA_BITS'($past(pwdata[DIST_BITS-1:0]))))
		else $error("miss distance readback mismatch");

endmodule

bind ray_capped_cylinder_intersect rcc_check u_rcc_check (.*);
